@@ hw/rtl/heat_diffusion_stencil_2d_defines.svh @@
// Assertion macros for the heat diffusion stencil block.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef HEAT_DIFFUSION_STENCIL_2D_DEFINES_SVH
`define HEAT_DIFFUSION_STENCIL_2D_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define HDS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HDS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/hds_pkg.sv @@
// Shared constants, codes and types of the heat diffusion stencil block.
// No dependencies; used by the interfaces, the cell unit and the top level.
package hds_pkg;

  localparam int MAX_ROWS_DEF   = 128;
  localparam int MAX_COLS_DEF   = 128;
  localparam int TEMP_WIDTH_DEF = 24;

  localparam int CMD_W      = 2;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 7;
  localparam int COEF_W     = 16;
  localparam int MODE_W     = 2;
  localparam int SIZE_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_V = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_H = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_FIXED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COPY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WRAP  = 2'd2;

  localparam logic [COEF_W-1:0] COEF_RESET = 16'd6554;
  localparam int                SIZE_RESET = 101;
  localparam int                SIZE_MIN   = 3;

  // Strobes from the sequencer to the shared multiply unit
  typedef struct packed {
    logic load_diff;
    logic mul_v;
    logic mul_h;
  } alu_ctl_t;

endpackage

@@ hw/rtl/hds_if.sv @@
// Valid/ready channel interfaces of the heat diffusion stencil block.
// Depends on hds_pkg for field widths.
interface hds_in_if #(
  parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic        [hds_pkg::CMD_W-1:0]  cmd;
  logic        [hds_pkg::ROW_W-1:0]  row;
  logic        [hds_pkg::COL_W-1:0]  col;
  logic signed [TEMP_WIDTH-1:0]      temperature;

  modport source (output valid, cmd, row, col, temperature, input ready);
  modport sink   (input valid, cmd, row, col, temperature, output ready);
endinterface

interface hds_out_if #(
  parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [TEMP_WIDTH-1:0] read_value;
  logic                         status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

interface hds_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [hds_pkg::CFG_IDX_W-1:0]     index;
  logic [hds_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/hds_cell_unit.sv @@
// Stencil update unit: one shared multiplier applied to both differences in turn.
// Depends on hds_pkg for the control struct and coefficient width.
module hds_cell_unit #(
  parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  hds_pkg::alu_ctl_t                 ctl_i,
  input  logic        [hds_pkg::COEF_W-1:0] coef_v_i,
  input  logic        [hds_pkg::COEF_W-1:0] coef_h_i,
  input  logic signed [TEMP_WIDTH-1:0]      t_i,
  input  logic signed [TEMP_WIDTH-1:0]      up_i,
  input  logic signed [TEMP_WIDTH-1:0]      dn_i,
  input  logic signed [TEMP_WIDTH-1:0]      lf_i,
  input  logic signed [TEMP_WIDTH-1:0]      rt_i,
  output logic signed [TEMP_WIDTH-1:0]      result_o
);

  localparam int DW = TEMP_WIDTH + 2;
  localparam int KW = hds_pkg::COEF_W + 1;
  localparam int PW = DW + KW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0]         dv_q, dh_q;
  logic signed [TEMP_WIDTH-1:0] t_q;
  logic signed [PW-1:0]         prod_q, acc_q;
  logic signed [KW-1:0]         mul_k;
  logic signed [DW-1:0]         mul_d;
  logic signed [SW-1:0]         sum_c, shr_c, nv_c;
  logic                         ovf_c;

  assign mul_k = ctl_i.mul_v ? $signed({1'b0, coef_v_i}) : $signed({1'b0, coef_h_i});
  assign mul_d = ctl_i.mul_v ? dv_q : dh_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_diff) begin
      dv_q <= DW'(up_i) + DW'(dn_i) - (DW'(t_i) <<< 1);
      dh_q <= DW'(lf_i) + DW'(rt_i) - (DW'(t_i) <<< 1);
      t_q  <= t_i;
    end
    if (ctl_i.mul_v || ctl_i.mul_h) begin
      prod_q <= PW'(mul_k) * PW'(mul_d);
    end
    if (ctl_i.mul_h) begin
      acc_q <= prod_q;
    end
  end

  // Round half up, then add the old value
  assign sum_c = SW'(acc_q) + SW'(prod_q) + SW'(32768);
  assign shr_c = sum_c >>> 16;
  assign nv_c  = shr_c + SW'(t_q);
  assign ovf_c = (nv_c[SW-1:TEMP_WIDTH-1] != {(SW-TEMP_WIDTH+1){1'b0}}) &&
                 (nv_c[SW-1:TEMP_WIDTH-1] != {(SW-TEMP_WIDTH+1){1'b1}});

  always_comb begin
    if (!ovf_c) begin
      result_o = nv_c[TEMP_WIDTH-1:0];
    end else if (nv_c[SW-1]) begin
      result_o = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
    end
  end

endmodule

@@ hw/rtl/heat_diffusion_stencil_2d.sv @@
// Top level of the 2D explicit heat diffusion stencil: grid banks and sequencer.
// Depends on hds_pkg, hds_if, hds_cell_unit and heat_diffusion_stencil_2d_defines.svh.
//
//  port   | dir | transaction
//  -------+-----+-----------------------------------------------
//  in_i   | in  | cmd, row, col, temperature
//  out_o  | out | read_value, status (one per input transaction)
//  cfg_i  | in  | index, data (register write, always ready)
//
// Load and unknown command are answered from the idle state; a read goes through a
// wait state for the registered bank read. A step visits every cell of the whole
// MAX_ROWS x MAX_COLS array, then makes the edge copies in copy or wrap mode; the
// single read port per bank and the shared multiplier set its pace.
// Reset clears control and registers; grid contents are undefined until loaded.
// A result not yet taken blocks the next transaction unless out_o is ready that cycle.
`include "heat_diffusion_stencil_2d_defines.svh"

module heat_diffusion_stencil_2d #(
  parameter int MAX_ROWS   = hds_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS   = hds_pkg::MAX_COLS_DEF,
  parameter int TEMP_WIDTH = hds_pkg::TEMP_WIDTH_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  hds_in_if.sink    in_i,
  hds_out_if.source out_o,
  hds_cfg_if.sink   cfg_i
);

  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int AW    = RB + CB;
  localparam int DEPTH = 2 ** AW;
  localparam int ROWS_RST = (hds_pkg::SIZE_RESET > MAX_ROWS) ? MAX_ROWS : hds_pkg::SIZE_RESET;
  localparam int COLS_RST = (hds_pkg::SIZE_RESET > MAX_COLS) ? MAX_COLS : hds_pkg::SIZE_RESET;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDWAIT = 4'd1;
  localparam logic [3:0] ST_TAP    = 4'd2;
  localparam logic [3:0] ST_DIFF   = 4'd3;
  localparam logic [3:0] ST_MULV   = 4'd4;
  localparam logic [3:0] ST_MULH   = 4'd5;
  localparam logic [3:0] ST_FIN    = 4'd6;
  localparam logic [3:0] ST_BRD    = 4'd7;
  localparam logic [3:0] ST_BWR    = 4'd8;

  localparam logic [2:0] TAP_CTR = 3'd0;
  localparam logic [2:0] TAP_UP  = 3'd1;
  localparam logic [2:0] TAP_DN  = 3'd2;
  localparam logic [2:0] TAP_LF  = 3'd3;
  localparam logic [2:0] TAP_RT  = 3'd4;
  localparam logic [2:0] TAP_END = 3'd5;

  // Control state
  logic [3:0]                        state_q, state_d;
  logic                              active_q, active_d;
  logic [RB-1:0]                     r_q, r_d;
  logic [CB-1:0]                     c_q, c_d;
  logic [2:0]                        tap_q, tap_d;
  logic                              bcol_q, bcol_d;
  logic                              bside_q, bside_d;
  logic                              out_valid_q, out_valid_d;
  logic [hds_pkg::COEF_W-1:0]        coefv_q, coefh_q;
  logic [hds_pkg::MODE_W-1:0]        mode_q;
  logic [RW-1:0]                     rows_q, rows_clamp;
  logic [CW-1:0]                     cols_q, cols_clamp;

  // Payload
  logic signed [TEMP_WIDTH-1:0]      out_value_q, out_value_d;
  logic                              out_status_q, out_status_d;
  logic signed [TEMP_WIDTH-1:0]      nb_q [5];
  logic signed [TEMP_WIDTH-1:0]      bank_a [DEPTH];
  logic signed [TEMP_WIDTH-1:0]      bank_b [DEPTH];
  logic signed [TEMP_WIDTH-1:0]      rda_q, rdb_q, rd_data;
  logic                              rsel_q;

  // Datapath controls
  logic                              in_fire, in_range, interior, per, edges_on;
  logic                              cell_last, out_set_c, step_done;
  logic [AW-1:0]                     in_addr, raddr_c, waddr_c, bsrc_c, bdst_c, tap_addr;
  logic                              rbank_c, wbank_c, we_c;
  logic signed [TEMP_WIDTH-1:0]      wdata_c, cell_res;
  logic [RB-1:0]                     r_next, rlast, rm2, top_src, bot_src;
  logic [CB-1:0]                     c_next, clast, cm2, lef_src, rig_src;
  logic [hds_pkg::SIZE_W-1:0]        size_cfg;
  hds_pkg::alu_ctl_t                 ctl_c;

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;
  assign size_cfg    = cfg_i.data[hds_pkg::SIZE_W-1:0];

  always_comb begin
    if (32'(size_cfg) < hds_pkg::SIZE_MIN) begin
      rows_clamp = RW'(hds_pkg::SIZE_MIN);
      cols_clamp = CW'(hds_pkg::SIZE_MIN);
    end else begin
      rows_clamp = (32'(size_cfg) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(size_cfg);
      cols_clamp = (32'(size_cfg) > MAX_COLS) ? CW'(MAX_COLS) : CW'(size_cfg);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coefv_q <= hds_pkg::COEF_RESET;
      coefh_q <= hds_pkg::COEF_RESET;
      mode_q  <= hds_pkg::MODE_FIXED;
      rows_q  <= RW'(ROWS_RST);
      cols_q  <= CW'(COLS_RST);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        hds_pkg::REG_COEF_V: coefv_q <= cfg_i.data;
        hds_pkg::REG_COEF_H: coefh_q <= cfg_i.data;
        hds_pkg::REG_MODE:   mode_q  <= cfg_i.data[hds_pkg::MODE_W-1:0];
        hds_pkg::REG_ROWS:   rows_q  <= rows_clamp;
        hds_pkg::REG_COLS:   cols_q  <= cols_clamp;
        default: ;
      endcase
    end
  end

  // ---------------- address helpers ----------------
  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_range = (32'(in_i.row) < 32'(rows_q)) && (32'(in_i.col) < 32'(cols_q));
  assign in_addr  = {RB'(in_i.row), CB'(in_i.col)};

  assign interior = (r_q != '0) && ((RW'(r_q) + RW'(1)) < rows_q) &&
                    (c_q != '0) && ((CW'(c_q) + CW'(1)) < cols_q);
  assign per      = (mode_q == hds_pkg::MODE_WRAP);
  assign edges_on = (mode_q == hds_pkg::MODE_COPY) || per;

  assign rlast   = RB'(rows_q - RW'(1));
  assign rm2     = RB'(rows_q - RW'(2));
  assign clast   = CB'(cols_q - CW'(1));
  assign cm2     = CB'(cols_q - CW'(2));
  assign top_src = per ? rm2 : RB'(1);
  assign bot_src = per ? RB'(1) : rm2;
  assign lef_src = per ? cm2 : CB'(1);
  assign rig_src = per ? CB'(1) : cm2;

  assign cell_last = (r_q == RB'(MAX_ROWS - 1)) && (c_q == CB'(MAX_COLS - 1));
  assign c_next    = (c_q == CB'(MAX_COLS - 1)) ? '0 : c_q + CB'(1);
  assign r_next    = (c_q == CB'(MAX_COLS - 1)) ? r_q + RB'(1) : r_q;

  always_comb begin
    case (tap_q)
      TAP_CTR: tap_addr = {r_q, c_q};
      TAP_UP:  tap_addr = {r_q - RB'(1), c_q};
      TAP_DN:  tap_addr = {r_q + RB'(1), c_q};
      TAP_LF:  tap_addr = {r_q, c_q - CB'(1)};
      default: tap_addr = {r_q, c_q + CB'(1)};
    endcase
  end

  always_comb begin
    if (!bcol_q) begin
      bsrc_c = bside_q ? {bot_src, c_q} : {top_src, c_q};
      bdst_c = bside_q ? {rlast, c_q}   : {RB'(0), c_q};
    end else begin
      bsrc_c = bside_q ? {r_q, rig_src} : {r_q, lef_src};
      bdst_c = bside_q ? {r_q, clast}   : {r_q, CB'(0)};
    end
  end

  // ---------------- grid banks ----------------
  always_comb begin
    raddr_c = in_addr;
    rbank_c = active_q;
    we_c    = 1'b0;
    wbank_c = ~active_q;
    waddr_c = {r_q, c_q};
    wdata_c = cell_res;
    unique case (state_q)
      ST_IDLE: begin
        we_c    = in_fire && (in_i.cmd == hds_pkg::CMD_LOAD) && in_range;
        wbank_c = active_q;
        waddr_c = in_addr;
        wdata_c = in_i.temperature;
      end
      ST_TAP: begin
        raddr_c = tap_addr;
        we_c    = (tap_q == TAP_UP) && !interior;
        wdata_c = rd_data;
      end
      ST_FIN: begin
        we_c = 1'b1;
      end
      ST_BRD: begin
        raddr_c = bsrc_c;
        rbank_c = ~active_q;
      end
      ST_BWR: begin
        we_c    = 1'b1;
        waddr_c = bdst_c;
        wdata_c = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_c && !wbank_c) begin
      bank_a[waddr_c] <= wdata_c;
    end
    if (we_c && wbank_c) begin
      bank_b[waddr_c] <= wdata_c;
    end
    rda_q  <= bank_a[raddr_c];
    rdb_q  <= bank_b[raddr_c];
    rsel_q <= rbank_c;
  end

  assign rd_data = rsel_q ? rdb_q : rda_q;

  // Neighbor capture, one tap behind the read address
  always_ff @(posedge clk_i) begin
    if (state_q == ST_TAP) begin
      case (tap_q)
        TAP_UP:  nb_q[0] <= rd_data;
        TAP_DN:  nb_q[1] <= rd_data;
        TAP_LF:  nb_q[2] <= rd_data;
        TAP_RT:  nb_q[3] <= rd_data;
        TAP_END: nb_q[4] <= rd_data;
        default: ;
      endcase
    end
  end

  // ---------------- shared update unit ----------------
  always_comb begin
    ctl_c.load_diff = (state_q == ST_DIFF);
    ctl_c.mul_v     = (state_q == ST_MULV);
    ctl_c.mul_h     = (state_q == ST_MULH);
  end

  hds_cell_unit #(
    .TEMP_WIDTH (TEMP_WIDTH)
  ) u_cell (
    .clk_i    (clk_i),
    .ctl_i    (ctl_c),
    .coef_v_i (coefv_q),
    .coef_h_i (coefh_q),
    .t_i      (nb_q[0]),
    .up_i     (nb_q[1]),
    .dn_i     (nb_q[2]),
    .lf_i     (nb_q[3]),
    .rt_i     (nb_q[4]),
    .result_o (cell_res)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    r_d          = r_q;
    c_d          = c_q;
    tap_d        = tap_q;
    bcol_d       = bcol_q;
    bside_d      = bside_q;
    out_set_c    = 1'b0;
    out_value_d  = '0;
    out_status_d = 1'b0;
    step_done    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_i.cmd)
            hds_pkg::CMD_LOAD: begin
              out_set_c    = 1'b1;
              out_status_d = !in_range;
            end
            hds_pkg::CMD_READ: begin
              if (in_range) begin
                state_d = ST_RDWAIT;
              end else begin
                out_set_c    = 1'b1;
                out_status_d = 1'b1;
              end
            end
            hds_pkg::CMD_STEP: begin
              r_d     = '0;
              c_d     = '0;
              tap_d   = TAP_CTR;
              state_d = ST_TAP;
            end
            default: out_set_c = 1'b1;
          endcase
        end
      end
      ST_RDWAIT: begin
        out_set_c   = 1'b1;
        out_value_d = rd_data;
        state_d     = ST_IDLE;
      end
      ST_TAP: begin
        if ((tap_q == TAP_UP) && !interior) begin
          // Edge or outside cell: carry the old value over
          tap_d = TAP_CTR;
          if (cell_last) begin
            if (edges_on) begin
              state_d = ST_BRD;
              c_d     = CB'(1);
              bcol_d  = 1'b0;
              bside_d = 1'b0;
            end else begin
              step_done = 1'b1;
            end
          end else begin
            r_d = r_next;
            c_d = c_next;
          end
        end else if (tap_q == TAP_END) begin
          state_d = ST_DIFF;
        end else begin
          tap_d = tap_q + 3'd1;
        end
      end
      ST_DIFF: state_d = ST_MULV;
      ST_MULV: state_d = ST_MULH;
      ST_MULH: state_d = ST_FIN;
      ST_FIN: begin
        tap_d   = TAP_CTR;
        state_d = ST_TAP;
        if (cell_last) begin
          if (edges_on) begin
            state_d = ST_BRD;
            c_d     = CB'(1);
            bcol_d  = 1'b0;
            bside_d = 1'b0;
          end else begin
            step_done = 1'b1;
          end
        end else begin
          r_d = r_next;
          c_d = c_next;
        end
      end
      ST_BRD: state_d = ST_BWR;
      ST_BWR: begin
        state_d = ST_BRD;
        bside_d = ~bside_q;
        if (bside_q) begin
          if (!bcol_q) begin
            if (c_q == cm2) begin
              bcol_d = 1'b1;
              r_d    = '0;
            end else begin
              c_d = c_q + CB'(1);
            end
          end else if (r_q == rlast) begin
            step_done = 1'b1;
          end else begin
            r_d = r_q + RB'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (step_done) begin
      active_d  = ~active_q;
      out_set_c = 1'b1;
      state_d   = ST_IDLE;
    end

    out_valid_d = (out_valid_q && !out_o.ready) || out_set_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      tap_q       <= TAP_CTR;
      bcol_q      <= 1'b0;
      bside_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      r_q         <= r_d;
      c_q         <= c_d;
      tap_q       <= tap_d;
      bcol_q      <= bcol_d;
      bside_q     <= bside_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_set_c) begin
      out_value_q  <= out_value_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_value = out_value_q;
  assign out_o.status     = out_status_q;

  // ---------------- assertions ----------------
  `HDS_ASSERT_NXT(a_step_swaps_bank, step_done, active_q != $past(active_q), "bank not swapped")
  `HDS_ASSERT_IMP(a_step_writes_spare, we_c && (state_q != ST_IDLE), wbank_c != active_q, "step wrote current bank")
  `HDS_ASSERT_IMP(a_result_slot_free, out_set_c, !out_valid_q || out_o.ready, "result overwrote pending result")
  `HDS_ASSERT_IMP(a_mulh_after_mulv, state_q == ST_MULH, $past(state_q) == ST_MULV, "multiply order broken")

endmodule

@@ dv/hds_tb_if.sv @@
// Testbench-side notes for the stencil channels: the channel interfaces come from
// hw/rtl/hds_if.sv (hds_in_if, hds_out_if, hds_cfg_if); this file only adds the
// command and mode codes the package leaves unnamed. Depends on hds_pkg.
`timescale 1ns / 100ps
package hds_tb_pkg;
  localparam logic [hds_pkg::CMD_W-1:0]  CMD_NOP   = 2'd3;
  localparam logic [hds_pkg::MODE_W-1:0] MODE_RSVD = 2'd3;
endpackage

@@ dv/heat_diffusion_stencil_2d_tb.sv @@
// Self-checking testbench of heat_diffusion_stencil_2d: a cell-accurate model of the
// grid banks predicts every result, a monitor compares them in order.
// Depends on hds_pkg, hds_tb_pkg and the channel interfaces of hds_if.sv.
`timescale 1ns / 100ps
module heat_diffusion_stencil_2d_tb;

  localparam int TW    = hds_pkg::TEMP_WIDTH_DEF;
  localparam int NR    = hds_pkg::MAX_ROWS_DEF;
  localparam int NC    = hds_pkg::MAX_COLS_DEF;
  localparam int CELLS = NR * NC;
  localparam int STALL_LIMIT = 500000;

  typedef logic signed [TW-1:0] temp_t;
  typedef struct packed {
    temp_t read_value;
    logic  status;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  hds_in_if  in_if ();
  hds_out_if out_if ();
  hds_cfg_if cfg_if ();

  heat_diffusion_stencil_2d u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Grid model: two banks, a written flag per cell, and the register file
  temp_t         grid [2][CELLS];
  bit            written [2][CELLS];
  bit            cur_bank;
  logic [15:0]   coef_v, coef_h;
  logic [1:0]    bnd_mode;
  logic [7:0]    rows_reg, cols_reg;

  result_t       pending_results[$];
  int            fail_count;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            idle_cycles;

  function automatic int grid_rows();
    return (rows_reg < 3) ? 3 : (rows_reg > NR) ? NR : int'(rows_reg);
  endfunction

  function automatic int grid_cols();
    return (cols_reg < 3) ? 3 : (cols_reg > NC) ? NC : int'(cols_reg);
  endfunction

  function automatic temp_t diffuse_cell(temp_t t, temp_t up, temp_t dn, temp_t lf,
                                         temp_t rt);
    longint dv, dh, acc, res;
    dv  = longint'(up) + longint'(dn) - 2 * longint'(t);
    dh  = longint'(lf) + longint'(rt) - 2 * longint'(t);
    acc = longint'(coef_v) * dv + longint'(coef_h) * dh + 32768;
    res = longint'(t) + (acc >>> 16);
    if (res > 64'sd8388607) res = 64'sd8388607;
    if (res < -64'sd8388608) res = -64'sd8388608;
    return temp_t'(res);
  endfunction

  task automatic advance_grid();
    int  r, c, i, rr, cc, top_s, bot_s, lef_s, rig_s;
    bit  s, d, wrap;
    s = cur_bank;
    d = ~cur_bank;
    rr = grid_rows();
    cc = grid_cols();
    for (i = 0; i < CELLS; i++) begin
      grid[d][i]    = grid[s][i];
      written[d][i] = written[s][i];
    end
    for (r = 1; r + 1 < rr; r++)
      for (c = 1; c + 1 < cc; c++) begin
        i = r * NC + c;
        grid[d][i] = diffuse_cell(grid[s][i], grid[s][i-NC], grid[s][i+NC],
                                  grid[s][i-1], grid[s][i+1]);
      end
    if (bnd_mode == hds_pkg::MODE_COPY || bnd_mode == hds_pkg::MODE_WRAP) begin
      wrap  = (bnd_mode == hds_pkg::MODE_WRAP);
      top_s = wrap ? rr - 2 : 1;
      bot_s = wrap ? 1 : rr - 2;
      lef_s = wrap ? cc - 2 : 1;
      rig_s = wrap ? 1 : cc - 2;
      for (c = 1; c + 1 < cc; c++) begin
        grid[d][c]             = grid[d][top_s*NC + c];
        grid[d][(rr-1)*NC + c] = grid[d][bot_s*NC + c];
      end
      for (r = 0; r < rr; r++) begin
        grid[d][r*NC]        = grid[d][r*NC + lef_s];
        grid[d][r*NC + cc-1] = grid[d][r*NC + rig_s];
      end
    end
    cur_bank = d;
  endtask

  task automatic predict_item(logic [1:0] cmd, logic [6:0] row, logic [6:0] col,
                              temp_t temp);
    result_t res;
    int      i;
    res = '0;
    i   = int'(row) * NC + int'(col);
    if (cmd == hds_pkg::CMD_LOAD || cmd == hds_pkg::CMD_READ) begin
      if (row >= grid_rows() || col >= grid_cols()) res.status = 1'b1;
      else if (cmd == hds_pkg::CMD_LOAD) begin
        grid[cur_bank][i]    = temp;
        written[cur_bank][i] = 1'b1;
      end else res.read_value = grid[cur_bank][i];
    end else if (cmd == hds_pkg::CMD_STEP) advance_grid();
    pending_results.push_back(res);
  endtask

  // Send one command; valid stays high across back-to-back transactions
  task automatic send_item(logic [1:0] cmd, logic [6:0] row, logic [6:0] col,
                           temp_t temp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.row         <= row;
    in_if.col         <= col;
    in_if.temperature <= temp;
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(cmd, row, col, temp);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Leave valid high; the caller drops it after the last write
  task automatic write_reg(logic [hds_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      hds_pkg::REG_COEF_V: coef_v   = data;
      hds_pkg::REG_COEF_H: coef_h   = data;
      hds_pkg::REG_MODE:   bnd_mode = data[1:0];
      hds_pkg::REG_ROWS:   rows_reg = data[7:0];
      hds_pkg::REG_COLS:   cols_reg = data[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic setup_grid(logic [15:0] cv, logic [15:0] ch, logic [1:0] mode,
                            logic [7:0] rows, logic [7:0] cols);
    wait_idle();
    write_reg(hds_pkg::REG_COEF_V, cv);
    write_reg(hds_pkg::REG_COEF_H, ch);
    write_reg(hds_pkg::REG_MODE, {14'd0, mode});
    write_reg(hds_pkg::REG_ROWS, {8'd0, rows});
    write_reg(hds_pkg::REG_COLS, {8'd0, cols});
    cfg_if.valid <= 1'b0;
  endtask

  function automatic temp_t rand_temp();
    case ($urandom_range(0, 7))
      0: return temp_t'(24'h800000);
      1: return temp_t'(24'h7FFFFF);
      2, 3: return temp_t'($urandom);
      default: return temp_t'($signed($urandom_range(0, 131071)) - 65536);
    endcase
  endfunction

  // Load every unwritten cell of the grid in use so a step never sees garbage
  task automatic fill_grid();
    int r, c;
    for (r = 0; r < grid_rows(); r++)
      for (c = 0; c < grid_cols(); c++)
        if (!written[cur_bank][r*NC + c])
          send_item(hds_pkg::CMD_LOAD, 7'(r), 7'(c), rand_temp());
  endtask

  task automatic read_grid();
    int r, c;
    for (r = 0; r < grid_rows(); r++)
      for (c = 0; c < grid_cols(); c++)
        send_item(hds_pkg::CMD_READ, 7'(r), 7'(c), rand_temp());
  endtask

  task automatic send_random_item();
    int          r, c;
    logic [1:0]  cmd;
    case ($urandom_range(0, 9))
      0: begin
        // address outside the grid in use
        cmd = $urandom_range(0, 1) ? hds_pkg::CMD_LOAD : hds_pkg::CMD_READ;
        do begin
          r = $urandom_range(0, 127);
          c = $urandom_range(0, 127);
        end while (r < grid_rows() && c < grid_cols());
        send_item(cmd, 7'(r), 7'(c), rand_temp());
      end
      1: send_item(hds_tb_pkg::CMD_NOP, 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)), rand_temp());
      2, 3, 4, 5: begin
        r = $urandom_range(0, grid_rows() - 1);
        c = $urandom_range(0, grid_cols() - 1);
        send_item(written[cur_bank][r*NC + c] ? hds_pkg::CMD_READ : hds_pkg::CMD_LOAD,
                  7'(r), 7'(c), rand_temp());
      end
      default: send_item(hds_pkg::CMD_LOAD, 7'($urandom_range(0, grid_rows() - 1)),
                         7'($urandom_range(0, grid_cols() - 1)), rand_temp());
    endcase
  endtask

  task automatic test_reset_defaults();
    // registers at reset: 101 x 101 grid
    send_item(hds_pkg::CMD_LOAD, 7'd100, 7'd100, temp_t'(24'h7FFFFF));
    send_item(hds_pkg::CMD_READ, 7'd100, 7'd100, '0);
    send_item(hds_pkg::CMD_LOAD, 7'd0, 7'd0, temp_t'(24'h800000));
    send_item(hds_pkg::CMD_READ, 7'd0, 7'd0, '0);
    send_item(hds_pkg::CMD_LOAD, 7'd101, 7'd5, temp_t'(24'h123456));
    send_item(hds_pkg::CMD_READ, 7'd5, 7'd101, '0);
    send_item(hds_pkg::CMD_READ, 7'd127, 7'd127, '0);
    send_item(hds_tb_pkg::CMD_NOP, 7'd127, 7'd127, temp_t'(24'hFFFFFF));
    // sizes below and above range clamp to 3 and 128
    setup_grid(hds_pkg::COEF_RESET, hds_pkg::COEF_RESET, hds_pkg::MODE_FIXED, 8'd2, 8'd255);
    send_item(hds_pkg::CMD_LOAD, 7'd2, 7'd127, temp_t'(24'h000100));
    send_item(hds_pkg::CMD_READ, 7'd2, 7'd127, '0);
    send_item(hds_pkg::CMD_READ, 7'd3, 7'd0, '0);
    send_item(hds_pkg::CMD_LOAD, 7'd3, 7'd1, '0);
  endtask

  task automatic test_edge_modes();
    setup_grid(16'd13107, 16'd9830, hds_pkg::MODE_COPY, 8'd5, 8'd6);
    fill_grid();
    send_item(hds_pkg::CMD_STEP, '0, '0, '0);
    read_grid();
    setup_grid(16'd20000, 16'd3000, hds_pkg::MODE_WRAP, 8'd4, 8'd7);
    fill_grid();
    send_item(hds_pkg::CMD_STEP, '0, '0, '0);
    read_grid();
  endtask

  // Full row count with a narrow grid keeps the number of loads small
  task automatic test_full_grid();
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup_grid(16'hFFFF, 16'h0000, hds_tb_pkg::MODE_RSVD, 8'd128, 8'd3);
    fill_grid();
    send_item(hds_pkg::CMD_STEP, '0, '0, '0);
    for (k = 0; k < 60; k++)
      send_item(hds_pkg::CMD_READ, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 2)),
                '0);
    send_item(hds_pkg::CMD_READ, 7'd127, 7'd127, '0);
    send_item(hds_pkg::CMD_READ, 7'd0, 7'd0, '0);
  endtask

  task automatic test_random_phase(int snd_pct, int rcv_pct, int n);
    int          k;
    logic [15:0] cv, ch;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    cv = $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom_range(0, 40000));
    ch = $urandom_range(0, 3) == 0 ? 16'h0000 : 16'($urandom_range(0, 40000));
    setup_grid(cv, ch, 2'($urandom_range(0, 3)), 8'($urandom_range(1, 12)),
               8'($urandom_range(1, 12)));
    fill_grid();
    for (k = 0; k < n; k++) begin
      if (k == n / 2) begin
        // hold off until the grid is quiet, then run one step
        wait_idle();
        send_item(hds_pkg::CMD_STEP, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                  rand_temp());
      end
      send_random_item();
    end
  endtask

  // Receiver backpressure
  always @(negedge clk_i)
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

  // Result monitor
  always @(posedge clk_i) begin
    result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_value %0d status %0d", out_if.read_value,
               out_if.status);
        fail_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.read_value !== exp_res.read_value) begin
          $error("read_value mismatch: expected %0d actual %0d", exp_res.read_value,
                 out_if.read_value);
          fail_count++;
        end
        if (out_if.status !== exp_res.status) begin
          $error("status mismatch: expected %0d actual %0d", exp_res.status,
                 out_if.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.cmd         = hds_pkg::CMD_LOAD;
    in_if.row         = '0;
    in_if.col         = '0;
    in_if.temperature = '0;
    out_if.ready      = 1'b1;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = hds_pkg::REG_COEF_V;
    cfg_if.data       = '0;
    idle_cycles       = 0;
    fail_count        = 0;
    send_idle_pct     = 20;
    recv_idle_pct     = 84;
    cur_bank          = 1'b0;
    coef_v            = hds_pkg::COEF_RESET;
    coef_h            = hds_pkg::COEF_RESET;
    bnd_mode          = hds_pkg::MODE_FIXED;
    rows_reg          = 8'(hds_pkg::SIZE_RESET);
    cols_reg          = 8'(hds_pkg::SIZE_RESET);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_edge_modes();
    test_full_grid();
    test_random_phase(20, 84, 350);
    test_random_phase(84, 20, 350);
    test_random_phase(0, 0, 350);

    wait_idle();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/hds_pkg.sv
hw/rtl/hds_if.sv
hw/rtl/hds_cell_unit.sv
hw/rtl/heat_diffusion_stencil_2d.sv
dv/hds_tb_if.sv
dv/heat_diffusion_stencil_2d_tb.sv
